// ===== src/pipw_pkg.sv =====
// Shared constants and types for the winding-number point-in-polygon block.
package pipw_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_BITS_DEF   = 16;

   localparam int FIELD_BITS = 16;
   localparam int COUNT_BITS = 6;
   localparam int VCOUNT_BITS = 5;

   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 5'd4;

   // word index of the vertex_count register
   localparam logic REG_VERTEX_COUNT = 1'b0;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // per-cycle control from the sequencer to the edge unit
   typedef struct packed {
      logic start;   // first ring step: head is vertex 0
      logic eval;    // evaluate the edge prev -> current
      logic close;   // closing edge: current is the saved vertex 0
      logic done;    // last ring step of the transaction
   } pipw_step_type;

endpackage

// ===== src/pipw_cell.sv =====
// One vertex cell of the rotating vertex ring.
module pipw_cell #(
   parameter int COORD_BITS = pipw_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic                         shift,
   input  logic signed [COORD_BITS-1:0] wr_x,
   input  logic signed [COORD_BITS-1:0] wr_y,
   input  logic signed [COORD_BITS-1:0] nb_x,
   input  logic signed [COORD_BITS-1:0] nb_y,
   output logic signed [COORD_BITS-1:0] x_o,
   output logic signed [COORD_BITS-1:0] y_o
);
   import pipw_pkg::*;

   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] y_ff, y_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (load) begin
         x_in = wr_x;
         y_in = wr_y;
      end else if (shift) begin
         x_in = nb_x;
         y_in = nb_y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;

endmodule

// ===== src/pipw_edge.sv =====
// Edge unit: crossing test and cross-product sign, one edge per cycle, 3 stages.
module pipw_edge #(
   parameter int COORD_BITS = pipw_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pipw_pkg::pipw_step_type            step,
   input  logic signed [COORD_BITS-1:0]       cur_x,
   input  logic signed [COORD_BITS-1:0]       cur_y,
   input  logic signed [COORD_BITS-1:0]       pt_x,
   input  logic signed [COORD_BITS-1:0]       pt_y,
   output logic                               done_o,
   output logic signed [pipw_pkg::COUNT_BITS-1:0] count_o
);
   import pipw_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_BITS-1:0] sel_x, sel_y;

   // stage 1
   logic                 eval1_ff, done1_ff, up1_ff, dn1_ff;
   logic signed [DW-1:0] a1_ff, a2_ff, b1_ff, b2_ff;
   logic signed [DW-1:0] a1_in, a2_in, b1_in, b2_in;
   logic                 up1_in, dn1_in;
   // stage 2
   logic                 eval2_ff, done2_ff, up2_ff, dn2_ff;
   logic signed [PW-1:0] p_ff, q_ff, p_in, q_in;
   // stage 3
   logic                 done3_ff;
   logic signed [PW:0]   diff;
   logic                 pos, neg;
   logic signed [COUNT_BITS-1:0] count_ff, count_in;

   assign sel_x = step.close ? first_x_ff : cur_x;
   assign sel_y = step.close ? first_y_ff : cur_y;

   always_comb begin
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      if (step.start) begin
         first_x_in = cur_x;
         first_y_in = cur_y;
         prev_x_in  = cur_x;
         prev_y_in  = cur_y;
      end else if (step.eval) begin
         prev_x_in = sel_x;
         prev_y_in = sel_y;
      end
   end

   // side = (x2-x1)*(py-y1) - (px-x1)*(y2-y1)
   always_comb begin
      a1_in  = {sel_x[COORD_BITS-1], sel_x} - {prev_x_ff[COORD_BITS-1], prev_x_ff};
      a2_in  = {pt_y[COORD_BITS-1], pt_y} - {prev_y_ff[COORD_BITS-1], prev_y_ff};
      b1_in  = {pt_x[COORD_BITS-1], pt_x} - {prev_x_ff[COORD_BITS-1], prev_x_ff};
      b2_in  = {sel_y[COORD_BITS-1], sel_y} - {prev_y_ff[COORD_BITS-1], prev_y_ff};
      up1_in = (prev_y_ff <= pt_y) && (sel_y > pt_y);
      dn1_in = (prev_y_ff > pt_y) && (sel_y <= pt_y);
   end

   assign p_in = PW'(a1_ff) * PW'(a2_ff);
   assign q_in = PW'(b1_ff) * PW'(b2_ff);

   assign diff = {p_ff[PW-1], p_ff} - {q_ff[PW-1], q_ff};
   assign neg  = diff[PW];
   assign pos  = !diff[PW] && (diff != '0);

   always_comb begin
      count_in = count_ff;
      if (step.start) begin
         count_in = '0;
      end else if (eval2_ff && up2_ff && pos) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (eval2_ff && dn2_ff && neg) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      a1_ff      <= a1_in;
      a2_ff      <= a2_in;
      b1_ff      <= b1_in;
      b2_ff      <= b2_in;
      up1_ff     <= up1_in;
      dn1_ff     <= dn1_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      up2_ff     <= up1_ff;
      dn2_ff     <= dn1_ff;
      count_ff   <= count_in;
      if (reset) begin
         eval1_ff <= 1'b0;
         done1_ff <= 1'b0;
         eval2_ff <= 1'b0;
         done2_ff <= 1'b0;
         done3_ff <= 1'b0;
      end else begin
         eval1_ff <= step.eval;
         done1_ff <= step.done;
         eval2_ff <= eval1_ff;
         done2_ff <= done1_ff;
         done3_ff <= done2_ff;
      end
   end

   assign done_o  = done3_ff;
   assign count_o = count_ff;

endmodule

// ===== src/point_in_polygon_winding_top.sv =====
// Top level: vertex ring, sequencer, edge unit, register port and result register.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  operation, vertex_index, coord_x, coord_y
//  rsp      out        rsp_valid/rsp_stall  inside_res, winding_count
//  csr      in/out     APB psel/penable     vertex_count at byte address 0
//
// A query runs MAX_VERTICES+1 ring steps, rotating the vertex ring MAX_VERTICES times;
// steps 1 to vertex_count (at most MAX_VERTICES) each feed one edge into the edge unit.
// The result passes the edge-unit stages and the hold register into the result register.
// Reset clears control and sets vertex_count to 4; vertex contents are undefined
// until written. req_stall stays high from a query's acceptance until its result
// is in the result register; a full result register does not block acceptance.
module point_in_polygon_winding_top #(
   parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pipw_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [3:0]                           req_vertex_index,
   input  logic signed [pipw_pkg::FIELD_BITS-1:0] req_coord_x,
   input  logic signed [pipw_pkg::FIELD_BITS-1:0] req_coord_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_inside_res,
   output logic signed [pipw_pkg::COUNT_BITS-1:0] rsp_winding_count,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [2:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import pipw_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(MAX_VERTICES);

   logic [VCOUNT_BITS-1:0] vcount_ff, vcount_in;
   logic [CW-1:0]          n_vert;
   logic [CW-1:0]          t_ff, t_in;
   logic                   run_ff, run_in;
   logic                   busy_ff, busy_in;
   logic                   hold_ff, hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   inside_ff, inside_in;
   logic signed [COUNT_BITS-1:0] wcount_ff, wcount_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;

   logic                   req_accept, query_go, write_go, transfer, csr_wr;
   logic signed [31:0]     cx_wide, cy_wide;
   logic signed [COORD_BITS-1:0] cx, cy;
   logic                   ring_shift;
   pipw_step_type          step;
   logic                   edge_done;
   logic signed [COUNT_BITS-1:0] edge_count;

   logic signed [COORD_BITS-1:0] ring_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] ring_y [MAX_VERTICES];

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_VERTEX_COUNT) ? 32'(vcount_ff) : '0;
   assign vcount_in  = (csr_wr && csr_paddr[2] == REG_VERTEX_COUNT) ?
                       csr_pwdata[VCOUNT_BITS-1:0] : vcount_ff;

   assign n_vert = (32'(vcount_ff) > MAX_VERTICES) ? LAST_STEP : CW'(vcount_ff);

   // coordinates wrap or extend to COORD_BITS on entry
   assign cx_wide = 32'(req_coord_x);
   assign cy_wide = 32'(req_coord_y);
   assign cx      = cx_wide[COORD_BITS-1:0];
   assign cy      = cy_wide[COORD_BITS-1:0];

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign query_go   = req_accept && (req_operation == OP_QUERY);
   assign write_go   = req_accept && (req_operation == OP_WRITE);
   assign transfer   = hold_ff && (!rsp_valid_ff || !rsp_stall);

   // sequencer: ring steps 0..MAX_VERTICES, rotating MAX_VERTICES times
   always_comb begin
      step.start = run_ff && (t_ff == '0);
      step.eval  = run_ff && (t_ff != '0) && (t_ff <= n_vert);
      step.close = run_ff && (t_ff == n_vert);
      step.done  = run_ff && (t_ff == LAST_STEP);
      ring_shift = run_ff && (t_ff != LAST_STEP);
   end

   always_comb begin
      run_in = run_ff;
      t_in   = t_ff;
      if (query_go) begin
         run_in = 1'b1;
         t_in   = '0;
      end else if (run_ff) begin
         t_in = t_ff + CW'(1);
         if (t_ff == LAST_STEP) begin
            run_in = 1'b0;
            t_in   = '0;
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      inside_in    = inside_ff;
      wcount_in    = wcount_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      if (query_go) begin
         busy_in = 1'b1;
         px_in   = cx;
         py_in   = cy;
      end
      if (edge_done) begin
         hold_in = 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (transfer) begin
         busy_in      = 1'b0;
         hold_in      = 1'b0;
         rsp_valid_in = 1'b1;
         wcount_in    = edge_count;
         inside_in    = (edge_count != '0);
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      wcount_ff <= wcount_in;
      inside_ff <= inside_in;
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         run_ff       <= 1'b0;
         t_ff         <= '0;
         busy_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         run_ff       <= run_in;
         t_ff         <= t_in;
         busy_ff      <= busy_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // vertex ring: cell 0 is the head, each cell takes its upper neighbor
   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      localparam int NB = (k + 1) % MAX_VERTICES;
      logic load;
      assign load = write_go && (32'(req_vertex_index) == k);
      pipw_cell #(
         .COORD_BITS(COORD_BITS)
      ) u_cell (
         .clock(clock),
         .load (load),
         .shift(ring_shift),
         .wr_x (cx),
         .wr_y (cy),
         .nb_x (ring_x[NB]),
         .nb_y (ring_y[NB]),
         .x_o  (ring_x[k]),
         .y_o  (ring_y[k])
      );
   end

   pipw_edge #(
      .COORD_BITS(COORD_BITS)
   ) u_edge (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cur_x  (ring_x[0]),
      .cur_y  (ring_y[0]),
      .pt_x   (px_ff),
      .pt_y   (py_ff),
      .done_o (edge_done),
      .count_o(edge_count)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inside_res    = inside_ff;
   assign rsp_winding_count = wcount_ff;

`ifndef SYNTHESIS
   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> busy_ff)
      else $error("result held without a query in flight");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      edge_done |-> (busy_ff && !run_ff))
      else $error("edge unit finished outside a query");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_go |=> (busy_ff && run_ff && t_ff == '0))
      else $error("accepted query did not start the ring");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (t_ff <= LAST_STEP))
      else $error("ring step count out of range");
`endif

endmodule
